### rtl/core/mss_pkg.sv
package mss_pkg;

  // phase accumulator width: 2^32 is one full turn
  localparam int unsigned ACC_W = 32;
  localparam int unsigned ATAN_LEN = 24;

  // configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SYM_BITS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_PERIOD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECISION_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE     = 3'd3;

  // register reset values
  localparam logic [3:0] RST_SYM_BITS        = 4'd3;
  localparam logic [7:0] RST_SYM_PERIOD      = 8'd8;
  localparam logic [7:0] RST_DECISION_OFFSET = 8'd5;
  localparam logic       RST_OUTPUT_MODE     = 1'b1;

  localparam logic MODE_SYMBOL = 1'b0;
  localparam logic MODE_BYTE   = 1'b1;

  // atan(2^-k) as a fraction of one turn, truncated
  localparam logic [ACC_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // control carried alongside each sample in the rotation chain
  typedef struct packed {
    logic valid;
    logic zero;
  } mss_tag_t;

  // output format settings
  typedef struct packed {
    logic [3:0] bits;
    logic       mode;
  } mss_fmt_t;

endpackage

### rtl/core/mpsk_symbol_slicer_core.sv
// M-PSK hard-decision slicer: takes one complex sample per clock, skips the
// first decision_offset samples, then decides one sample in every symbol
// period. The phase comes from a chain of CORDIC_STAGES vectoring cells, is
// rounded to one of 2^n sectors (n bits per symbol) and Gray coded; in byte
// mode the symbols are packed MSB-first and only whole bytes come out.
// Throughput is one sample per clock, set by the fully pipelined cell chain;
// a decided sample passes the input register (loaded at the transfer), one
// register per cell, the quantiser register and the packer register on its
// way to the output. When out_ready is low with a result waiting, the whole
// pipeline holds and in_ready drops.
module mpsk_symbol_slicer_core #(
  parameter int unsigned SAMPLE_WIDTH  = 16,
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned COUNT_WIDTH   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_sample_q,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_value,
  input  logic                                 cfg_we,
  input  logic [mss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mss_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int unsigned XW = SAMPLE_WIDTH + 3;

  logic en;
  logic in_xfer;

  // configuration registers
  logic [3:0]             bits_r;
  logic [7:0]             spp_r;
  logic                   mode_r;
  mss_pkg::mss_fmt_t      fmt;

  // decision timing
  logic [COUNT_WIDTH-1:0] skip_r, skip_nxt;
  logic [COUNT_WIDTH-1:0] phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] period;
  logic [COUNT_WIDTH:0]   phase_inc;
  logic                   decide;

  // pre-rotation
  logic signed [XW-1:0]   xi, yi;
  logic signed [XW-1:0]   x0_nxt, y0_nxt;
  logic [mss_pkg::ACC_W-1:0] acc0_nxt;

  // cell chain taps
  mss_pkg::mss_tag_t          tag_c [CORDIC_STAGES+1];
  logic signed [XW-1:0]       x_c   [CORDIC_STAGES+1];
  logic signed [XW-1:0]       y_c   [CORDIC_STAGES+1];
  logic [mss_pkg::ACC_W-1:0]  acc_c [CORDIC_STAGES+1];

  mss_pkg::mss_tag_t          tag0_r;
  logic signed [XW-1:0]       x0_r, y0_r;
  logic [mss_pkg::ACC_W-1:0]  acc0_r;

  // pipeline advances unless a result is waiting and not taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign in_xfer  = in_valid && in_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= mss_pkg::RST_SYM_BITS;
      spp_r  <= mss_pkg::RST_SYM_PERIOD;
      mode_r <= mss_pkg::RST_OUTPUT_MODE;
    end else if (cfg_we) begin
      case (cfg_index)
        mss_pkg::CFG_SYM_BITS:    bits_r <= cfg_wdata[3:0];
        mss_pkg::CFG_SYM_PERIOD:  spp_r  <= cfg_wdata;
        mss_pkg::CFG_OUTPUT_MODE: mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign fmt.bits = bits_r;
  assign fmt.mode = mode_r;

  // skip and period counters
  always_comb begin
    period = COUNT_WIDTH'(spp_r);
    if (period == '0) begin
      period = COUNT_WIDTH'(1);
    end
    phase_inc = {1'b0, phase_r} + (COUNT_WIDTH+1)'(1);
    decide    = (skip_r == '0) && (phase_r == '0);

    skip_nxt  = skip_r;
    phase_nxt = phase_r;
    if (cfg_we && (cfg_index == mss_pkg::CFG_DECISION_OFFSET)) begin
      skip_nxt  = COUNT_WIDTH'(cfg_wdata);
      phase_nxt = '0;
    end else if (in_xfer) begin
      if (skip_r != '0) begin
        skip_nxt = skip_r - COUNT_WIDTH'(1);
      end else if (phase_inc >= {1'b0, period}) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_inc[COUNT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r  <= COUNT_WIDTH'(mss_pkg::RST_DECISION_OFFSET);
      phase_r <= '0;
    end else begin
      skip_r  <= skip_nxt;
      phase_r <= phase_nxt;
    end
  end

  // fold left half-plane into the right, starting half a turn round
  always_comb begin
    xi = XW'(in_sample_i);
    yi = XW'(in_sample_q);
    if (xi[XW-1]) begin
      x0_nxt   = -xi;
      y0_nxt   = -yi;
      acc0_nxt = 32'h80000000;
    end else begin
      x0_nxt   = xi;
      y0_nxt   = yi;
      acc0_nxt = '0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= '0;
    end else if (en) begin
      tag0_r.valid <= in_xfer && decide;
      tag0_r.zero  <= (xi == '0) && (yi == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r   <= x0_nxt;
      y0_r   <= y0_nxt;
      acc0_r <= acc0_nxt;
    end
  end

  assign tag_c[0] = tag0_r;
  assign x_c[0]   = x0_r;
  assign y_c[0]   = y0_r;
  assign acc_c[0] = acc0_r;

  // chain of rotation cells
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    mss_cordic_cell #(
      .XW    (XW),
      .SHIFT (k),
      .ATAN  (mss_pkg::ATAN_TURNS[k])
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_tag  (tag_c[k]),
      .in_x    (x_c[k]),
      .in_y    (y_c[k]),
      .in_acc  (acc_c[k]),
      .out_tag (tag_c[k+1]),
      .out_x   (x_c[k+1]),
      .out_y   (y_c[k+1]),
      .out_acc (acc_c[k+1])
    );
  end

  // quantiser, gray coder and byte packer
  mss_byte_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_tag    (tag_c[CORDIC_STAGES]),
    .in_acc    (acc_c[CORDIC_STAGES]),
    .fmt       (fmt),
    .out_valid (out_valid),
    .out_value (out_value)
  );

endmodule

### rtl/core/mss_cordic_cell.sv
module mss_cordic_cell #(
  parameter int unsigned XW    = 19,
  parameter int unsigned SHIFT = 0,
  parameter logic [31:0] ATAN  = 32'h20000000
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  mss_pkg::mss_tag_t            in_tag,
  input  logic signed [XW-1:0]         in_x,
  input  logic signed [XW-1:0]         in_y,
  input  logic [mss_pkg::ACC_W-1:0]    in_acc,
  output mss_pkg::mss_tag_t            out_tag,
  output logic signed [XW-1:0]         out_x,
  output logic signed [XW-1:0]         out_y,
  output logic [mss_pkg::ACC_W-1:0]    out_acc
);

  mss_pkg::mss_tag_t             tag_r;
  logic signed [XW-1:0]          x_r, x_nxt;
  logic signed [XW-1:0]          y_r, y_nxt;
  logic [mss_pkg::ACC_W-1:0]     acc_r, acc_nxt;

  // one vectoring micro-rotation, driving y towards zero
  always_comb begin
    if (!in_y[XW-1]) begin
      x_nxt   = in_x + (in_y >>> SHIFT);
      y_nxt   = in_y - (in_x >>> SHIFT);
      acc_nxt = in_acc + ATAN;
    end else begin
      x_nxt   = in_x - (in_y >>> SHIFT);
      y_nxt   = in_y + (in_x >>> SHIFT);
      acc_nxt = in_acc - ATAN;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= in_tag;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign out_tag = tag_r;
  assign out_x   = x_r;
  assign out_y   = y_r;
  assign out_acc = acc_r;

endmodule

### rtl/core/mss_byte_packer.sv
module mss_byte_packer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  mss_pkg::mss_tag_t          in_tag,
  input  logic [mss_pkg::ACC_W-1:0]  in_acc,
  input  mss_pkg::mss_fmt_t          fmt,
  output logic                       out_valid,
  output logic [7:0]                 out_value
);

  logic [3:0]  eff_bits;
  logic [31:0] acc_eff;
  logic [32:0] rounded;
  logic [32:0] sector;
  logic [7:0]  sym_mask;
  logic [7:0]  sym;

  logic        gvalid_r;
  logic [7:0]  gray_r, gray_nxt;

  logic [7:0]  pack_byte_r, pack_byte_nxt;
  logic [2:0]  bit_pos_r, bit_pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_value_r, out_value_nxt;

  // bits per symbol clamped to 1..8
  always_comb begin
    if (fmt.bits == 4'd0) begin
      eff_bits = 4'd1;
    end else if (fmt.bits > 4'd8) begin
      eff_bits = 4'd8;
    end else begin
      eff_bits = fmt.bits;
    end
  end

  // round phase to nearest sector, wrap and gray code
  always_comb begin
    acc_eff  = in_tag.zero ? 32'd0 : in_acc;
    rounded  = {1'b0, acc_eff} + (33'd1 << (5'd31 - 5'(eff_bits)));
    sector   = rounded >> (6'd32 - 6'(eff_bits));
    sym_mask = 8'((9'd1 << eff_bits) - 9'd1);
    sym      = sector[7:0] & sym_mask;
    gray_nxt = sym ^ (sym >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gvalid_r <= 1'b0;
    end else if (en) begin
      gvalid_r <= in_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gray_r <= gray_nxt;
    end
  end

  // msb-first packing, at most one byte completes per symbol
  always_comb begin
    logic [7:0] byte_v;
    logic [2:0] pos_v;
    logic       emit_v;
    logic [7:0] done_v;
    byte_v = pack_byte_r;
    pos_v  = bit_pos_r;
    emit_v = 1'b0;
    done_v = '0;
    for (int i = 7; i >= 0; i--) begin
      if (i < int'(eff_bits)) begin
        if (gray_r[3'(i)]) begin
          byte_v[pos_v] = 1'b1;
        end
        if (pos_v == 3'd0) begin
          done_v = byte_v;
          emit_v = 1'b1;
          byte_v = '0;
          pos_v  = 3'd7;
        end else begin
          pos_v = pos_v - 3'd1;
        end
      end
    end

    pack_byte_nxt = pack_byte_r;
    bit_pos_nxt   = bit_pos_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    if (gvalid_r) begin
      if (fmt.mode == mss_pkg::MODE_SYMBOL) begin
        out_valid_nxt = 1'b1;
        out_value_nxt = gray_r;
      end else begin
        pack_byte_nxt = byte_v;
        bit_pos_nxt   = pos_v;
        out_valid_nxt = emit_v;
        out_value_nxt = done_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_byte_r <= '0;
      bit_pos_r   <= 3'd7;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pack_byte_r <= pack_byte_nxt;
      bit_pos_r   <= bit_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule
